@@ design/lmc_pkg.sv @@
package lmc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;
  localparam int unsigned LedCount   = 4;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CfgWidth-1:0] BlinkPeriodRst = CfgWidth'(2000);
  localparam logic [CfgWidth-1:0] DebounceRst    = CfgWidth'(200);

  localparam logic [CfgIdxW-1:0] CfgBlinkPeriod = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDebounce    = CfgIdxW'(1);

  typedef enum logic [1:0] {
    ModeStop   = 2'd0,
    ModeBlink  = 2'd1,
    ModeShift  = 2'd2,
    ModeManual = 2'd3
  } mode_e;

  typedef enum logic {
    OpTick  = 1'b0,
    OpPress = 1'b1
  } op_e;

  typedef struct packed {
    logic [CfgWidth-1:0] blink_period;
    logic [CfgWidth-1:0] debounce_interval;
  } cfg_t;

  typedef struct packed {
    logic [LedCount-1:0] led_pattern;
    mode_e               mode_now;
    logic                press_accepted;
  } result_t;

endpackage

@@ design/lmc_cfg.sv @@
module lmc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lmc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lmc_pkg::CfgWidth-1:0] cfg_data_i,
  output lmc_pkg::cfg_t               cfg_o
);
  import lmc_pkg::*;

  logic [CfgWidth-1:0] blink_period_q, blink_period_d;
  logic [CfgWidth-1:0] debounce_q, debounce_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    blink_period_d = blink_period_q;
    debounce_d     = debounce_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBlinkPeriod: blink_period_d = cfg_data_i;
        CfgDebounce:    debounce_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q <= BlinkPeriodRst;
      debounce_q     <= DebounceRst;
    end else begin
      blink_period_q <= blink_period_d;
      debounce_q     <= debounce_d;
    end
  end

  assign cfg_o.blink_period      = blink_period_q;
  assign cfg_o.debounce_interval = debounce_q;

endmodule

@@ design/lmc_core.sv @@
module lmc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                operation_i,
  input  logic [1:0]          switch_index_i,
  input  lmc_pkg::cfg_t       cfg_i,
  output lmc_pkg::result_t    result_o
);
  import lmc_pkg::*;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  mode_e                 mode_q, mode_d;
  logic [LedCount-1:0]   led_q, led_d;
  logic                  phase_q, phase_d;
  logic [1:0]            shift_q, shift_d;
  logic [2:0]            manual_q, manual_d;
  logic [CountWidth-1:0] period_cnt_q, period_cnt_d;
  logic [CountWidth-1:0] since_q, since_d;

  logic [CmpWidth-1:0]   period_ext;
  logic [CountWidth-1:0] cnt_inc;
  logic                  pass;
  logic                  new_phase;
  logic [2:0]            manual_flip;
  mode_e                 entry_mode;
  logic                  do_entry;

  always_comb begin
    // zero period behaves as one
    period_ext = (cfg_i.blink_period == '0) ? CmpWidth'(1) : CmpWidth'(cfg_i.blink_period);
    cnt_inc    = period_cnt_q + CountWidth'(1);
    pass       = (CmpWidth'(since_q) >= CmpWidth'(cfg_i.debounce_interval))
                 || (since_q == CountMax);
    new_phase  = ~phase_q;
    manual_flip = manual_q ^ (3'b001 << switch_index_i);
  end

  always_comb begin
    mode_d       = mode_q;
    led_d        = led_q;
    phase_d      = phase_q;
    shift_d      = shift_q;
    manual_d     = manual_q;
    period_cnt_d = period_cnt_q;
    since_d      = since_q;
    do_entry     = 1'b0;
    entry_mode   = ModeStop;

    if (operation_i == OpTick) begin
      if (since_q != CountMax) since_d = since_q + CountWidth'(1);
      if (mode_q == ModeBlink || mode_q == ModeShift) begin
        if (CmpWidth'(cnt_inc) < period_ext) begin
          period_cnt_d = cnt_inc;
        end else begin
          period_cnt_d = '0;
          if (mode_q == ModeBlink) begin
            phase_d = new_phase;
            led_d   = {LedCount{new_phase}};
          end else begin
            led_d   = LedCount'(1) << shift_q;
            shift_d = shift_q + 2'd1;
          end
        end
      end
    end else if (pass) begin
      since_d = '0;
      if (mode_q == ModeManual) begin
        if (switch_index_i == 2'd3) begin
          do_entry   = 1'b1;
          entry_mode = ModeStop;
        end else begin
          manual_d = manual_flip;
          led_d[switch_index_i] = manual_flip[switch_index_i];
        end
      end else begin
        do_entry = 1'b1;
        case (switch_index_i)
          2'd0:    entry_mode = ModeBlink;
          2'd1:    entry_mode = ModeShift;
          2'd2:    entry_mode = ModeManual;
          default: entry_mode = ModeStop;
        endcase
      end
    end

    if (do_entry) begin
      mode_d       = entry_mode;
      led_d        = '0;
      phase_d      = 1'b0;
      shift_d      = '0;
      period_cnt_d = '0;
      if (entry_mode == ModeStop || entry_mode == ModeManual) manual_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeStop;
      led_q        <= '0;
      phase_q      <= 1'b0;
      shift_q      <= '0;
      manual_q     <= '0;
      period_cnt_q <= '0;
      since_q      <= CountMax;
    end else if (fire_i) begin
      mode_q       <= mode_d;
      led_q        <= led_d;
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      manual_q     <= manual_d;
      period_cnt_q <= period_cnt_d;
      since_q      <= since_d;
    end
  end

  assign result_o.led_pattern    = led_d;
  assign result_o.mode_now       = mode_d;
  assign result_o.press_accepted = (operation_i == OpPress) && pass;

endmodule

@@ design/led_mode_controller_top.sv @@
// led mode controller: four leds driven by ticks and debounced switch presses
//
// input channel: in_valid_i / in_stall_o with operation_i (0 tick, 1 press)
// and switch_index_i. a beat is taken when valid is high and stall is low.
// output channel: out_valid_o / out_stall_i with led_pattern_o, mode_now_o
// and press_accepted_o, one result beat for every input beat, in order.
// config channel: cfg_valid_i / cfg_ready_o, index 0 blink period,
// index 1 debounce interval; ready is always high. write only while idle.
//
// each input beat is held in the input register, then the state update
// writes its result into the result register when that register can advance.
// throughput is one item per cycle unless the output stalls; the state update
// is a single pass of short logic between the input and result registers.
// when the receiver stalls the result register holds, the input register
// fills, and in_stall_o rises only once both are occupied.
// reset clears both pipeline stages, puts the block in stop mode with all
// leds off, and loads the registers with period 2000 and debounce 200.
module led_mode_controller_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [1:0]                   switch_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [3:0]                   led_pattern_o,
  output logic [1:0]                   mode_now_o,
  output logic                         press_accepted_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lmc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lmc_pkg::CfgWidth-1:0] cfg_data_i
);
  import lmc_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic       in_valid_q;
  logic       op_q;
  logic [1:0] sw_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       advance;
  logic       fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  lmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lmc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .operation_i    (op_q),
    .switch_index_i (sw_q),
    .cfg_i          (cfg),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= fire;
    end
  end

  // payload registers load on their beat only
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q <= operation_i;
      sw_q <= switch_index_i;
    end
    if (fire) out_q <= result;
  end

  assign out_valid_o      = out_valid_q;
  assign led_pattern_o    = out_q.led_pattern;
  assign mode_now_o       = out_q.mode_now;
  assign press_accepted_o = out_q.press_accepted;

endmodule

@@ verif/led_mode_controller_top_test.sv @@
`timescale 1ns / 100ps

module led_mode_controller_top_test;
  import lmc_pkg::*;

  typedef struct packed {
    op_e        op;
    logic [1:0] sw;
  } switch_event_t;

  localparam int unsigned IdlePct     = 27;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned ReportMax   = 10;
  localparam logic [1:0]  StopSwitch  = 2'd3;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                operation_i    = OpTick;
  logic [1:0]          switch_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [3:0]          led_pattern_o;
  logic [1:0]          mode_now_o;
  logic                press_accepted_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgWidth-1:0] cfg_data_i     = '0;

  led_mode_controller_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .switch_index_i   (switch_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .led_pattern_o    (led_pattern_o),
    .mode_now_o       (mode_now_o),
    .press_accepted_o (press_accepted_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // predicted led state and register copies
  logic [CfgWidth-1:0]   cfg_period   = BlinkPeriodRst;
  logic [CfgWidth-1:0]   cfg_debounce = DebounceRst;
  mode_e                 pred_mode       = ModeStop;
  logic [3:0]            pred_leds       = '0;
  logic                  pred_phase      = 1'b0;
  logic [1:0]            pred_shift      = '0;
  logic [2:0]            pred_manual     = '0;
  logic [CountWidth-1:0] pred_period_cnt = '0;
  logic [CountWidth-1:0] pred_since      = '1;

  switch_event_t switch_events[$];
  result_t       led_results_due[$];
  switch_event_t cur_event;
  result_t       due;

  bit          no_idle    = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_done  = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_presses  = 0;
  int unsigned n_taken    = 0;
  int unsigned n_checked  = 0;

  function automatic void enter_mode(mode_e m);
    pred_mode       = m;
    pred_leds       = '0;
    pred_phase      = 1'b0;
    pred_shift      = '0;
    pred_period_cnt = '0;
    if (m == ModeStop || m == ModeManual) pred_manual = '0;
  endfunction

  function automatic result_t advance_leds(switch_event_t ev);
    result_t               r;
    logic [CountWidth-1:0] period;
    logic [3:0]            bit_sel;
    r.press_accepted = 1'b0;
    if (ev.op == OpTick) begin
      // a zero period behaves like one
      period = (cfg_period == '0) ? CountWidth'(1) : CountWidth'(cfg_period);
      if (pred_since != '1) pred_since = pred_since + 1'b1;
      if (pred_mode == ModeBlink || pred_mode == ModeShift) begin
        pred_period_cnt = pred_period_cnt + 1'b1;
        if (pred_period_cnt >= period) begin
          pred_period_cnt = '0;
          if (pred_mode == ModeBlink) begin
            pred_phase = ~pred_phase;
            pred_leds  = {4{pred_phase}};
          end else begin
            pred_leds  = 4'b0001 << pred_shift;
            pred_shift = pred_shift + 1'b1;
          end
        end
      end
    end else if (pred_since >= cfg_debounce || pred_since == '1) begin
      r.press_accepted = 1'b1;
      pred_since = '0;
      if (pred_mode == ModeManual && ev.sw != StopSwitch) begin
        bit_sel     = 4'b0001 << ev.sw;
        pred_manual = pred_manual ^ bit_sel[2:0];
        pred_leds   = (pred_leds & ~bit_sel) | ({1'b0, pred_manual} & bit_sel);
      end else if (pred_mode == ModeManual) begin
        enter_mode(ModeStop);
      end else begin
        case (ev.sw)
          2'd0:    enter_mode(ModeBlink);
          2'd1:    enter_mode(ModeShift);
          2'd2:    enter_mode(ModeManual);
          default: enter_mode(ModeStop);
        endcase
      end
    end
    r.led_pattern = pred_leds;
    r.mode_now    = pred_mode;
    return r;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sender: predicts at every accepted beat, then offers the next event
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      operation_i    <= OpTick;
      switch_index_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due = advance_leds(cur_event);
        led_results_due.push_back(due);
        if (cur_event.op == OpTick) n_ticks++;
        else n_presses++;
        if (due.press_accepted) n_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (switch_events.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
          cur_event      = switch_events.pop_front();
          in_valid_i     <= 1'b1;
          operation_i    <= cur_event.op;
          switch_index_i <= cur_event.sw;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks result beats and drives stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (led_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("unexpected result beat: leds %h mode %0d accepted %0d",
                     led_pattern_o, mode_now_o, press_accepted_o);
        end else begin
          due = led_results_due.pop_front();
          n_checked++;
          if (led_pattern_o !== due.led_pattern || mode_now_o !== due.mode_now ||
              press_accepted_o !== due.press_accepted) begin
            fail_count++;
            if (fail_count <= ReportMax)
              $display("beat %0d: expected leds %h mode %0d accepted %0d, got leds %h mode %0d accepted %0d",
                       n_checked, due.led_pattern, due.mode_now, due.press_accepted,
                       led_pattern_o, mode_now_o, press_accepted_o);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
        // long hold-off so both pipeline stages fill and the input stalls
        out_stall_i <= 1'b1;
        hold_left   <= HoldCycles;
        hold_done   <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("no beat for %0d cycles, giving up", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic void queue_event(op_e op, logic [1:0] sw);
    switch_event_t ev;
    ev.op = op;
    ev.sw = sw;
    switch_events.push_back(ev);
  endfunction

  task automatic drain();
    while (switch_events.size() != 0 || led_results_due.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [CfgWidth-1:0] period,
                          input logic [CfgWidth-1:0] debounce);
    for (int i = 0; i < 2; i++) begin
      @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? CfgBlinkPeriod : CfgDebounce;
      cfg_data_i  <= (i == 0) ? period : debounce;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_valid_i <= 1'b0;
      if (i == 0) cfg_period = period;
      else cfg_debounce = debounce;
    end
    @(negedge clk_i);
  endtask

  task automatic random_phase(input logic [CfgWidth-1:0] period,
                              input logic [CfgWidth-1:0] debounce,
                              input bit calm, input bit squeeze);
    set_regs(period, debounce);
    no_idle    = calm;
    hold_armed = squeeze;
    for (int n = 0; n < PhaseItems; n++)
      queue_event(($urandom_range(99) < 65) ? OpTick : OpPress, 2'($urandom_range(3)));
    drain();
    no_idle    = 1'b0;
    hold_armed = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers: saturated counter lets the first press in, the next is bounced
    queue_event(OpPress, 2'd2);
    queue_event(OpPress, 2'd0);
    queue_event(OpTick, 2'd3);
    queue_event(OpPress, StopSwitch);
    drain();

    // fastest period, no debounce: every mode and the manual toggles
    set_regs(CfgWidth'(1), '0);
    queue_event(OpPress, 2'd0);
    queue_event(OpPress, 2'd1);
    queue_event(OpPress, 2'd2);
    queue_event(OpPress, 2'd0);
    queue_event(OpTick, 2'd0);
    queue_event(OpPress, StopSwitch);
    queue_event(OpPress, 2'd0);
    queue_event(OpTick, 2'd1);
    queue_event(OpTick, 2'd2);
    queue_event(OpPress, 2'd0);
    queue_event(OpPress, 2'd1);
    repeat (5) queue_event(OpTick, 2'($urandom_range(3)));
    queue_event(OpPress, StopSwitch);
    queue_event(OpPress, 2'd2);
    queue_event(OpPress, StopSwitch);
    drain();

    // widest period and interval: presses soon after an accepted one are bounced
    set_regs('1, '0);
    queue_event(OpPress, 2'd0);
    drain();
    set_regs('1, '1);
    no_idle = 1'b1;
    repeat (40) queue_event(OpTick, 2'($urandom_range(3)));
    queue_event(OpPress, StopSwitch);
    queue_event(OpTick, 2'd0);
    queue_event(OpPress, StopSwitch);
    drain();
    no_idle = 1'b0;

    random_phase(CfgWidth'(1), '0, 1'b1, 1'b0);
    random_phase('0, CfgWidth'(2), 1'b0, 1'b1);
    random_phase(CfgWidth'($urandom_range(6, 1)), CfgWidth'($urandom_range(8)), 1'b0, 1'b0);
    random_phase(CfgWidth'($urandom_range(6, 1)), CfgWidth'($urandom_range(8)), 1'b0, 1'b0);
    random_phase(CfgWidth'(4), CfgWidth'(3), 1'b0, 1'b0);
    random_phase(CfgWidth'(2), CfgWidth'(1), 1'b0, 1'b0);

    drain();
    if (led_results_due.size() != 0) fail_count++;
    $display("ran %0d ticks and %0d presses (%0d passed debounce), %0d result beats checked",
             n_ticks, n_presses, n_taken, n_checked);
    $display("periods 0 to 65535, debounce 0 to 65535, one long output hold-off");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ led_mode_controller_top.f @@
design/lmc_pkg.sv
design/lmc_cfg.sv
design/lmc_core.sv
design/led_mode_controller_top.sv
verif/led_mode_controller_top_test.sv
